[rtl/vrba_pkg.sv]
package vrba_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE    = 2'd1;
  localparam logic [1:0] STATUS_DOUBLE_FREE = 2'd2;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // widest word the population count covers
  localparam int MAX_WORD_BITS = 64;

  localparam logic [MAX_WORD_BITS-1:0] POP_M1 = 64'h5555_5555_5555_5555;
  localparam logic [MAX_WORD_BITS-1:0] POP_M2 = 64'h3333_3333_3333_3333;
  localparam logic [MAX_WORD_BITS-1:0] POP_M4 = 64'h0f0f_0f0f_0f0f_0f0f;

  // swar population count
  function automatic logic [6:0] pop_count(input logic [MAX_WORD_BITS-1:0] v);
    logic [MAX_WORD_BITS-1:0] x;
    x = v - ((v >> 1) & POP_M1);
    x = (x & POP_M2) + ((x >> 2) & POP_M2);
    x = (x + (x >> 4)) & POP_M4;
    x = x + (x >> 8);
    x = x + (x >> 16);
    x = x + (x >> 32);
    return x[6:0];
  endfunction

endpackage

[rtl/vrba_ram.sv]
module vrba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/variable_run_bitmap_allocator_unit.sv]
// Contiguous-run allocator over a pool of NUM_WORDS words of WORD_BITS units. An allocate
// transfer asks for run_length units; the block fails at once, without a scan, when the
// length is zero or above WORD_BITS or the largest-hole hint is below the request,
// otherwise it scans the active words circularly from the last-hit word, one word per
// cycle through the used-bit memory read port, and takes the lowest fitting run in the
// first word that has one. A free transfer that releases a run goes through these steps:
// a reciprocal multiply splits the unit index into word and bit, then the used and
// run-marker words are read, the run length is decoded, checked and the word is written
// back. A free outside the active pool ends once the word is known, and a double free
// ends after the check. After reset a clearing pass zeroes the used-bit memory, one word
// per cycle, with in_stall high; configuration writes are taken at any time. The result
// of one request is held in an output register, so the next request is taken while that
// result waits on out_stall.
module variable_run_bitmap_allocator_unit #(
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_words_in_use,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [5:0]  in_run_length,
  input  logic [10:0] in_unit_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [10:0] out_granted_index,
  output logic [5:0]  out_freed_length,
  output logic        out_pool_empty
);

  localparam int WI_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W  = $clog2(NUM_WORDS + 1);
  localparam int CW     = (CNT_W > 7) ? CNT_W : 7;
  localparam int BP_W   = $clog2(WORD_BITS);
  localparam int LEN_W  = $clog2(WORD_BITS + 1);
  localparam int GI_W   = (WI_W + 7 > 11) ? WI_W + 7 : 11;
  // unit index / WORD_BITS as multiply by reciprocal, exact for 11-bit indices
  localparam int DIV_SH = 11 + BP_W;
  localparam longint RECIP = ((64'd1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W = 11 + DIV_SH + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AL_RD,
    ST_AL_CHK,
    ST_AL_WR,
    ST_FR_DIV,
    ST_FR_REM,
    ST_FR_LEN,
    ST_FR_CHK,
    ST_FR_WR,
    ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [WI_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic [6:0]           wiu_r, wiu_nxt;
  logic [WI_W-1:0]      hint_word_r, hint_word_nxt;
  logic [LEN_W-1:0]     lhh_r, lhh_nxt;
  logic [CNT_W-1:0]     busy_r, busy_nxt;
  logic [5:0]           n_r, n_nxt;
  logic [WORD_BITS-1:0] mask_r, mask_nxt;
  logic [WORD_BITS-1:0] pos_ok_r, pos_ok_nxt;
  logic [10:0]          unit_r, unit_nxt;
  logic [10:0]          q_r, q_nxt;
  logic [BP_W-1:0]      b_r, b_nxt;
  logic [WI_W-1:0]      scan_w_r, scan_w_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [WORD_BITS-1:0] old_r, old_nxt;
  logic [WORD_BITS-1:0] marks_r, marks_nxt;
  logic [BP_W-1:0]      p_r, p_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [WORD_BITS-1:0] nv_r, nv_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [10:0]          res_gidx_r, res_gidx_nxt;
  logic [5:0]           res_flen_r, res_flen_nxt;
  logic                 res_empty_r, res_empty_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [10:0]          out_gidx_r, out_gidx_nxt;
  logic [5:0]           out_flen_r, out_flen_nxt;
  logic                 out_empty_r, out_empty_nxt;

  // memory ports
  logic                 used_we;
  logic [WI_W-1:0]      used_waddr;
  logic [WORD_BITS-1:0] used_wdata;
  logic [WORD_BITS-1:0] used_rd;
  logic                 marks_we;
  logic [WORD_BITS-1:0] marks_wdata;
  logic [WORD_BITS-1:0] marks_rd;
  logic [WI_W-1:0]      rd_addr;

  // working signals
  logic [CNT_W-1:0]     cnt;
  logic [CW-1:0]        wiu_ext;
  logic                 in_xfer;
  logic [WI_W-1:0]      start_w;
  logic [WI_W-1:0]      next_w;
  logic [WORD_BITS-1:0] fit;
  logic                 fit_any;
  logic [BP_W-1:0]      fit_p;
  logic [WORD_BITS-1:0] run_al;
  logic [6:0]           end_bit;
  logic [GI_W-1:0]      gidx;
  logic [PROD_W-1:0]    prod;
  logic [WORD_BITS:0]   marks_sh;
  logic [LEN_W-1:0]     zpos;
  logic [LEN_W-1:0]     lim;
  logic [WORD_BITS-1:0] run_fr;
  logic [WORD_BITS-1:0] free_bits;
  logic [6:0]           free_cnt;
  logic [CNT_W-1:0]     busy_dec;

  vrba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_used_ram (
    .clk     (clk),
    .wr_en   (used_we),
    .wr_addr (used_waddr),
    .wr_data (used_wdata),
    .rd_addr (rd_addr),
    .rd_data (used_rd)
  );

  vrba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_marks_ram (
    .clk     (clk),
    .wr_en   (marks_we),
    .wr_addr (scan_w_r),
    .wr_data (marks_wdata),
    .rd_addr (rd_addr),
    .rd_data (marks_rd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  // active word count clamped to 1..NUM_WORDS
  assign wiu_ext = CW'(wiu_r);
  always_comb begin
    if (wiu_r == 7'd0) begin
      cnt = CNT_W'(1);
    end else if (wiu_ext > CW'(NUM_WORDS)) begin
      cnt = CNT_W'(NUM_WORDS);
    end else begin
      cnt = CNT_W'(wiu_r);
    end
  end

  // stale hint restarts the scan at word zero
  assign start_w = (CNT_W'(hint_word_r) < cnt) ? hint_word_r : '0;
  assign next_w  = (CNT_W'(scan_w_r) == cnt - CNT_W'(1)) ? '0 : scan_w_r + WI_W'(1);

  // lowest position in the word read where the requested run fits
  always_comb begin
    fit_any = 1'b0;
    fit_p   = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      fit[p] = pos_ok_r[p] && (((used_rd >> p) & mask_r) == '0);
    end
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (fit[p]) begin
        fit_any = 1'b1;
        fit_p   = BP_W'(p);
      end
    end
  end

  // allocate write-back data; the run mark is ones closed by a zero
  assign run_al  = mask_r << p_r;
  assign end_bit = 7'(p_r) + 7'(n_r) - 7'd1;
  assign gidx    = GI_W'(scan_w_r) * GI_W'(WORD_BITS) + GI_W'(p_r);

  // word and bit of a freed unit
  assign prod = PROD_W'(unit_r) * PROD_W'(RECIP);

  // run length from the marker word: up to and including the first zero
  assign marks_sh = {1'b0, marks_rd} >> b_r;
  assign lim      = LEN_W'(WORD_BITS) - LEN_W'(b_r);
  always_comb begin
    zpos = LEN_W'(WORD_BITS);
    for (int i = WORD_BITS; i >= 0; i--) begin
      if (!marks_sh[i]) begin
        zpos = LEN_W'(i);
      end
    end
  end

  assign run_fr    = ({WORD_BITS{1'b1}} >> (LEN_W'(WORD_BITS) - len_r)) << b_r;
  assign free_bits = ~nv_r;
  assign free_cnt  = vrba_pkg::pop_count(vrba_pkg::MAX_WORD_BITS'(free_bits));
  assign busy_dec  = (busy_r != '0) ? busy_r - CNT_W'(1) : busy_r;

  // memory read address
  always_comb begin
    case (state_r)
      ST_AL_RD:  rd_addr = start_w;
      ST_AL_CHK: rd_addr = next_w;
      ST_FR_REM: rd_addr = q_r[WI_W-1:0];
      default:   rd_addr = scan_w_r;
    endcase
  end

  // memory writes
  always_comb begin
    used_we     = 1'b0;
    used_waddr  = scan_w_r;
    used_wdata  = nv_r;
    marks_we    = 1'b0;
    marks_wdata = (marks_r | run_al) & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << end_bit);
    case (state_r)
      ST_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_idx_r;
        used_wdata = '0;
      end
      ST_AL_WR: begin
        used_we    = 1'b1;
        used_wdata = old_r | run_al;
        marks_we   = 1'b1;
      end
      ST_FR_WR: begin
        used_we = 1'b1;
      end
      default: begin
        used_we = 1'b0;
      end
    endcase
  end

  // control and datapath next state
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    wiu_nxt        = cfg_wr_en ? cfg_words_in_use : wiu_r;
    hint_word_nxt  = hint_word_r;
    lhh_nxt        = lhh_r;
    busy_nxt       = busy_r;
    n_nxt          = n_r;
    mask_nxt       = mask_r;
    pos_ok_nxt     = pos_ok_r;
    unit_nxt       = unit_r;
    q_nxt          = q_r;
    b_nxt          = b_r;
    scan_w_nxt     = scan_w_r;
    k_nxt          = k_r;
    old_nxt        = old_r;
    marks_nxt      = marks_r;
    p_nxt          = p_r;
    len_nxt        = len_r;
    nv_nxt         = nv_r;
    res_status_nxt = res_status_r;
    res_gidx_nxt   = res_gidx_r;
    res_flen_nxt   = res_flen_r;
    res_empty_nxt  = res_empty_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_gidx_nxt   = out_gidx_r;
    out_flen_nxt   = out_flen_r;
    out_empty_nxt  = out_empty_r;

    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + WI_W'(1);
        if (clr_idx_r == WI_W'(NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          res_status_nxt = vrba_pkg::STATUS_OK;
          res_gidx_nxt   = '0;
          res_flen_nxt   = '0;
          res_empty_nxt  = 1'b0;
          n_nxt          = in_run_length;
          unit_nxt       = in_unit_index;
          mask_nxt       = {WORD_BITS{1'b1}} >> (7'(WORD_BITS) - 7'(in_run_length));
          for (int p = 0; p < WORD_BITS; p++) begin
            pos_ok_nxt[p] = (7'(p) + 7'(in_run_length)) <= 7'(WORD_BITS);
          end
          if (in_opcode == vrba_pkg::OP_ALLOC) begin
            if (in_run_length == 6'd0 || 7'(in_run_length) > 7'(WORD_BITS) ||
                7'(lhh_r) < 7'(in_run_length)) begin
              // bad length or hint too small: fail without a scan
              res_status_nxt = vrba_pkg::STATUS_NO_SPACE;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_AL_RD;
            end
          end else begin
            state_nxt = ST_FR_DIV;
          end
        end
      end

      ST_AL_RD: begin
        scan_w_nxt = start_w;
        k_nxt      = '0;
        state_nxt  = ST_AL_CHK;
      end

      ST_AL_CHK: begin
        if (fit_any) begin
          old_nxt   = used_rd;
          marks_nxt = marks_rd;
          p_nxt     = fit_p;
          state_nxt = ST_AL_WR;
        end else if (k_r == cnt - CNT_W'(1)) begin
          // no word fits: remember the largest run that may still fit
          lhh_nxt        = LEN_W'(n_r - 6'd1);
          res_status_nxt = vrba_pkg::STATUS_NO_SPACE;
          state_nxt      = ST_DONE;
        end else begin
          k_nxt      = k_r + CNT_W'(1);
          scan_w_nxt = next_w;
        end
      end

      ST_AL_WR: begin
        if (old_r == '0) begin
          busy_nxt = busy_r + CNT_W'(1);
        end
        hint_word_nxt  = scan_w_r;
        res_status_nxt = vrba_pkg::STATUS_OK;
        res_gidx_nxt   = gidx[10:0];
        state_nxt      = ST_DONE;
      end

      ST_FR_DIV: begin
        q_nxt     = prod[DIV_SH +: 11];
        state_nxt = ST_FR_REM;
      end

      ST_FR_REM: begin
        if (q_r >= 11'(cnt)) begin
          res_status_nxt = vrba_pkg::STATUS_DOUBLE_FREE;
          state_nxt      = ST_DONE;
        end else begin
          b_nxt      = BP_W'(unit_r - 11'(q_r * WORD_BITS));
          scan_w_nxt = q_r[WI_W-1:0];
          state_nxt  = ST_FR_LEN;
        end
      end

      ST_FR_LEN: begin
        old_nxt   = used_rd;
        len_nxt   = (zpos == lim) ? lim : zpos + LEN_W'(1);
        state_nxt = ST_FR_CHK;
      end

      ST_FR_CHK: begin
        nv_nxt = old_r & ~run_fr;
        if ((old_r & run_fr) != run_fr) begin
          res_status_nxt = vrba_pkg::STATUS_DOUBLE_FREE;
          state_nxt      = ST_DONE;
        end else begin
          state_nxt = ST_FR_WR;
        end
      end

      ST_FR_WR: begin
        res_status_nxt = vrba_pkg::STATUS_OK;
        res_flen_nxt   = 6'(len_r);
        if (nv_r == '0) begin
          lhh_nxt       = LEN_W'(WORD_BITS);
          busy_nxt      = busy_dec;
          res_empty_nxt = (busy_dec == '0);
        end else if (lhh_r != LEN_W'(WORD_BITS)) begin
          if (7'(lhh_r) < free_cnt) begin
            lhh_nxt = LEN_W'(free_cnt);
          end
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_gidx_nxt   = res_gidx_r;
          out_flen_nxt   = res_flen_r;
          out_empty_nxt  = res_empty_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      wiu_r       <= 7'd64;
      hint_word_r <= '0;
      lhh_r       <= LEN_W'(WORD_BITS);
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      wiu_r       <= wiu_nxt;
      hint_word_r <= hint_word_nxt;
      lhh_r       <= lhh_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r          <= n_nxt;
    mask_r       <= mask_nxt;
    pos_ok_r     <= pos_ok_nxt;
    unit_r       <= unit_nxt;
    q_r          <= q_nxt;
    b_r          <= b_nxt;
    scan_w_r     <= scan_w_nxt;
    k_r          <= k_nxt;
    old_r        <= old_nxt;
    marks_r      <= marks_nxt;
    p_r          <= p_nxt;
    len_r        <= len_nxt;
    nv_r         <= nv_nxt;
    res_status_r <= res_status_nxt;
    res_gidx_r   <= res_gidx_nxt;
    res_flen_r   <= res_flen_nxt;
    res_empty_r  <= res_empty_nxt;
    out_status_r <= out_status_nxt;
    out_gidx_r   <= out_gidx_nxt;
    out_flen_r   <= out_flen_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_gidx_r;
  assign out_freed_length  = out_flen_r;
  assign out_pool_empty    = out_empty_r;

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  // the busy word count never exceeds the pool
  a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r <= CNT_W'(NUM_WORDS))
    else $error("busy word count out of range");

  // the hole hint never exceeds one word
  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lhh_r <= LEN_W'(WORD_BITS))
    else $error("largest hole hint out of range");

  // a granted run and a freed length never come together, and status 3 never shows
  a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gidx_r == '0 || out_flen_r == '0) && out_status_r != 2'd3)
    else $error("malformed result");

endmodule

[tb/variable_run_bitmap_allocator_unit_tb.sv]
`timescale 1ns / 1ps

module variable_run_bitmap_allocator_unit_tb;

  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = 64;

  // one response of the allocator, as the block reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] granted_index;
    logic [5:0]  freed_length;
    logic        pool_empty;
  } alloc_response_t;

  // dut ports, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_words_in_use = 7'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = vrba_pkg::OP_ALLOC;
  logic [5:0]  in_run_length = 6'd0;
  logic [10:0] in_unit_index = 11'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [10:0] out_granted_index;
  logic [5:0]  out_freed_length;
  logic        out_pool_empty;

  // shadow copy of the pool state
  logic [WORD_BITS-1:0] used_map  [NUM_WORDS];
  logic [WORD_BITS-1:0] mark_map  [NUM_WORDS];
  // marker bits that were ever written; mid-run frees in random traffic start on such bits
  logic [WORD_BITS-1:0] mark_seen [NUM_WORDS];
  logic [5:0]           last_hit_word;
  logic [5:0]           hole_hint;
  logic [6:0]           busy_words;
  logic [6:0]           pool_words_cfg;

  alloc_response_t awaited_responses [$];
  // start units of granted runs, candidates for later frees
  logic [10:0]     live_runs [$];
  int              mismatch_count = 0;
  // no gaps on the request side and no stalls on the result side
  bit              quiet_traffic = 1'b0;
  int              stall_burst = 0;

  variable_run_bitmap_allocator_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_words_in_use  (cfg_words_in_use),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_run_length     (in_run_length),
    .in_unit_index     (in_unit_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_freed_length  (out_freed_length),
    .out_pool_empty    (out_pool_empty)
  );

  always #2 clk = ~clk;

  // word count register, clamped to the pool size
  function automatic int active_pool_words();
    if (pool_words_cfg == 7'd0) return 1;
    if (pool_words_cfg > NUM_WORDS) return NUM_WORDS;
    return int'(pool_words_cfg);
  endfunction

  function automatic logic [WORD_BITS-1:0] low_ones(input int n);
    logic [63:0] t;
    t = (64'd1 << n) - 64'd1;
    return t[WORD_BITS-1:0];
  endfunction

  // expected response of one request; updates the shadow state
  function automatic alloc_response_t allocate_or_release(input logic op,
                                                          input logic [5:0] len,
                                                          input logic [10:0] unit);
    alloc_response_t r;
    int count, first, w, b, n, freec;
    logic [WORD_BITS-1:0] run, old, rest;
    bit found;
    r = '0;
    count = active_pool_words();
    if (op == vrba_pkg::OP_ALLOC) begin
      n = int'(len);
      r.status = vrba_pkg::STATUS_NO_SPACE;
      // bad length or hole hint too small: refused with no state change
      if (n < 1 || n > WORD_BITS || int'(hole_hint) < n) return r;
      // a hint word outside the active pool restarts the scan at word 0
      first = (int'(last_hit_word) < count) ? int'(last_hit_word) : 0;
      found = 1'b0;
      for (int k = 0; k < count && !found; k++) begin
        w = (first + k) % count;
        old = used_map[w];
        for (int p = 0; p + n <= WORD_BITS && !found; p++) begin
          run = low_ones(n) << p;
          if ((old & run) == '0) begin
            found = 1'b1;
            if (old == '0) busy_words = busy_words + 7'd1;
            used_map[w] = old | run;
            // ones over the run, a single zero on its last unit
            mark_map[w] = (mark_map[w] | run) & ~(low_ones(1) << (p + n - 1));
            mark_seen[w] = mark_seen[w] | run;
            last_hit_word = 6'(w);
            r.status = vrba_pkg::STATUS_OK;
            r.granted_index = 11'(w * WORD_BITS + p);
          end
        end
      end
      // whole pool scanned without a fit
      if (!found) hole_hint = 6'(n - 1);
    end else begin
      w = int'(unit) / WORD_BITS;
      b = int'(unit) % WORD_BITS;
      r.status = vrba_pkg::STATUS_DOUBLE_FREE;
      if (w >= count) return r;
      // run length: marks up to and including the first zero
      rest = mark_map[w] >> b;
      n = 0;
      while (n < WORD_BITS - b && rest[n]) n++;
      if (n < WORD_BITS - b) n++;
      run = low_ones(n) << b;
      if ((used_map[w] & run) != run) return r;
      used_map[w] = used_map[w] & ~run;
      r.status = vrba_pkg::STATUS_OK;
      r.freed_length = 6'(n);
      if (used_map[w] == '0) begin
        hole_hint = 6'(WORD_BITS);
        if (busy_words != 7'd0) busy_words = busy_words - 7'd1;
        r.pool_empty = (busy_words == 7'd0);
      end else if (hole_hint != WORD_BITS) begin
        freec = $countones(~used_map[w]);
        if (int'(hole_hint) < freec) hole_hint = 6'(freec);
      end
    end
    return r;
  endfunction

  // one request transfer; valid stays up so back-to-back items need no extra edge
  task automatic issue_request(input logic op, input logic [5:0] len,
                               input logic [10:0] unit);
    alloc_response_t want;
    if (!quiet_traffic && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_run_length <= len;
    in_unit_index <= unit;
    do @(posedge clk); while (in_stall);
    want = allocate_or_release(op, len, unit);
    awaited_responses.push_back(want);
    if (op == vrba_pkg::OP_ALLOC && want.status == vrba_pkg::STATUS_OK) begin
      live_runs.push_back(want.granted_index);
    end
  endtask

  // the field the operation ignores gets random content
  task automatic request_alloc(input int len);
    issue_request(vrba_pkg::OP_ALLOC, 6'(len), 11'($urandom_range(2047)));
  endtask

  task automatic request_free(input int unit);
    issue_request(vrba_pkg::OP_FREE, 6'($urandom_range(63)), 11'(unit));
  endtask

  // sender holds off until every response is back, then the block settles
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pool_words(input logic [6:0] words);
    wait_drained();
    cfg_wr_en        <= 1'b1;
    cfg_words_in_use <= words;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    pool_words_cfg = words;
  endtask

  // zero length and lengths beyond a word, including all bits set
  task automatic test_bad_lengths();
    request_alloc(0);
    request_alloc(33);
    request_alloc(63);
  endtask

  // two-word pool: fill, failed scan, hint refusal, double and outside frees
  task automatic test_fill_and_release();
    write_pool_words(7'd2);
    request_alloc(32);
    request_alloc(32);
    request_alloc(1);      // full scan misses, hint drops to zero
    request_alloc(1);      // refused by the hint alone
    request_free(0);       // word empties, hint back to full
    request_free(0);       // second release of the same run
    request_free(64);      // word beyond the active pool
    request_free(2047);
    request_free(32);      // last busy word empties
    request_alloc(5);
    request_alloc(3);
    request_free(34);      // release from the middle of a run
    request_free(32);      // tail of that run already released
    request_free(37);
  endtask

  // register at zero: one word while the last hit sits in word 1
  task automatic test_stale_hint();
    write_pool_words(7'd0);
    request_alloc(20);
    request_alloc(10);
  endtask

  // failed scan lowers the hint, a partial free raises it to the free count
  task automatic test_hint_raise();
    request_alloc(4);
    request_free(20);
    request_alloc(12);
  endtask

  // mostly allocate and release of live runs, plus stale, mid-run and
  // outside-pool releases and bad lengths
  task automatic test_random_traffic(input logic [6:0] words, input int items,
                                     input bit big_runs, input bit calm);
    int count, pick, w, b, roll, len;
    logic [10:0] unit;
    write_pool_words(words);
    quiet_traffic = calm;
    count = active_pool_words();
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      w = $urandom_range(count - 1);
      if (roll >= 55 && roll < 88 && live_runs.size() != 0) begin
        pick = $urandom_range(live_runs.size() - 1);
        unit = live_runs[pick];
        // now and then keep the entry so it is released twice
        if ($urandom_range(9) != 0) live_runs.delete(pick);
        request_free(int'(unit));
      end else if (roll >= 88 && roll < 95 && mark_seen[w] != '0) begin
        b = $urandom_range(WORD_BITS - 1);
        while (!mark_seen[w][b]) b = (b + 1) % WORD_BITS;
        request_free(w * WORD_BITS + b);
      end else if (roll >= 95 && count < NUM_WORDS) begin
        request_free($urandom_range(2047, count * WORD_BITS));
      end else begin
        roll = $urandom_range(99);
        if (roll == 0) len = 0;
        else if (roll < 4) len = $urandom_range(63, 33);
        else if (big_runs) len = $urandom_range(32, 12);
        else if (roll < 75) len = $urandom_range(6, 1);
        else len = $urandom_range(32, 1);
        request_alloc(len);
      end
    end
  endtask

  // result side stalls in random bursts, none in quiet stretches
  always @(posedge clk) begin
    if (!rst_n || quiet_traffic) begin
      out_stall   <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst == 0) begin
      out_stall   <= ($urandom_range(2) == 0);
      stall_burst <= $urandom_range(16, 1);
    end else begin
      stall_burst <= stall_burst - 1;
    end
  end

  // every result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    alloc_response_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected result: status %0d index %0d length %0d empty %0d",
                 $time, out_status, out_granted_index, out_freed_length, out_pool_empty);
        mismatch_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_granted_index !== want.granted_index) begin
          $display("%0t: granted_index expected %0d actual %0d",
                   $time, want.granted_index, out_granted_index);
          mismatch_count++;
        end
        if (out_freed_length !== want.freed_length) begin
          $display("%0t: freed_length expected %0d actual %0d",
                   $time, want.freed_length, out_freed_length);
          mismatch_count++;
        end
        if (out_pool_empty !== want.pool_empty) begin
          $display("%0t: pool_empty expected %0d actual %0d",
                   $time, want.pool_empty, out_pool_empty);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      used_map[i]  = '0;
      mark_map[i]  = '0;
      mark_seen[i] = '0;
    end
    last_hit_word  = '0;
    hole_hint      = 6'(WORD_BITS);
    busy_words     = '0;
    pool_words_cfg = 7'd64;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // the block holds in_stall through its clearing pass
    test_bad_lengths();
    test_fill_and_release();
    test_stale_hint();
    test_hint_raise();
    test_random_traffic(7'd3, 160, 1'b0, 1'b0);
    test_random_traffic(7'd127, 220, 1'b1, 1'b0);
    test_random_traffic(7'd0, 100, 1'b0, 1'b0);
    test_random_traffic(7'd8, 200, 1'b0, 1'b0);
    test_random_traffic(7'd64, 150, 1'b1, 1'b0);
    test_random_traffic(7'd2, 100, 1'b0, 1'b0);
    test_random_traffic(7'd5, 120, 1'b0, 1'b1);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // far beyond the slowest legal run, full scans and long stalls included
  initial begin
    #2_500_000;
    $display("%0t: timeout, %0d results outstanding", $time, awaited_responses.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
